>>> design/double_ended_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Double-ended priority queue assertion macros
// Shared concurrent assertion forms for the queue checker.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DEPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DEPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/depq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended priority queue package
// Widths, operation and status codes, and the per-cell command type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package depq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 11;
    // is_empty, min_value, max_value, live_total packed, rounded to whole bytes.
    localparam int RES_BITS     = 1 + DATA_W + DATA_W + TOTAL_W;
    localparam int RES_W        = ((RES_BITS + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_POP_MAX = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP_MIN = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] NO_VALUE = '1;

    typedef struct packed {
        logic ins;
        logic pop_min;
        logic pop_max;
    } t_cell_op;

endpackage

>>> design/depq_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// Holds the i-th smallest and the i-th largest live value and trades them
// with its neighbors on insert and removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module depq_cell (
    input  logic                                   i_clk,
    input  depq_pkg::t_cell_op                     i_op,
    input  logic signed [depq_pkg::DATA_W-1:0]     i_value,
    input  logic                                   i_live,
    input  logic signed [depq_pkg::DATA_W-1:0]     i_left_lo,
    input  logic                                   i_left_le,
    input  logic signed [depq_pkg::DATA_W-1:0]     i_left_hi,
    input  logic                                   i_left_ge,
    input  logic signed [depq_pkg::DATA_W-1:0]     i_right_lo,
    input  logic signed [depq_pkg::DATA_W-1:0]     i_right_hi,
    output logic signed [depq_pkg::DATA_W-1:0]     o_lo,
    output logic signed [depq_pkg::DATA_W-1:0]     o_hi,
    output logic                                   o_lo_le,
    output logic                                   o_hi_ge
);

    logic signed [depq_pkg::DATA_W-1:0] r_lo;
    logic signed [depq_pkg::DATA_W-1:0] r_hi;
    logic signed [depq_pkg::DATA_W-1:0] n_lo;
    logic signed [depq_pkg::DATA_W-1:0] n_hi;

    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_lo_le = (r_lo <= i_value);
    assign o_hi_ge = (r_hi >= i_value);

    // The ascending row keeps its value while it is not above the new one;
    // otherwise the first such cell takes the new value and the rest shift up.
    always_comb begin
        n_lo = r_lo;
        if (i_op.ins) begin
            if (i_live && o_lo_le) begin
                n_lo = r_lo;
            end else if (i_left_le) begin
                n_lo = i_value;
            end else begin
                n_lo = i_left_lo;
            end
        end else if (i_op.pop_min) begin
            n_lo = i_right_lo;
        end
    end

    // The descending row mirrors the ascending one.
    always_comb begin
        n_hi = r_hi;
        if (i_op.ins) begin
            if (i_live && o_hi_ge) begin
                n_hi = r_hi;
            end else if (i_left_ge) begin
                n_hi = i_value;
            end else begin
                n_hi = i_left_hi;
            end
        end else if (i_op.pop_max) begin
            n_hi = i_right_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
    end

endmodule

>>> design/double_ended_priority_queue.sv
// ----------------------------------------------------------------------------
// Double-ended priority queue
// Multiset of signed values with insert, remove-largest and remove-smallest.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser selects the operation (insert,
// remove one maximum, remove one minimum) and tdata carries the value to
// insert. Every request returns one result on m_axis: tuser holds the status
// and tdata the empty flag, minimum, maximum and live count after the request.
// The values sit in a row of CAPACITY cells. Cell i holds the i-th smallest
// and the i-th largest live value, so both ends are always read at cell 0.
// An insert shifts each row up behind the insertion point; a
// removal shifts one row down and only shortens the other.
// An accepted request is registered into the cells and the count; its result
// is then registered into the output register when the output is free. The
// block takes no new request until that result is loaded. While a result
// is stalled by the receiver the block still accepts one more request; it
// then holds tready low until the output frees up.
// Reset empties the queue at once; cell contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_priority_queue #(
    parameter int CAPACITY = depq_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [depq_pkg::DATA_W-1:0]        i_s_axis_tdata,  // value
    input  logic [depq_pkg::FUNC_W-1:0]        i_s_axis_tuser,  // func
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // is_empty, min_value, max_value, live_total, zero fill
    output logic [depq_pkg::RES_W-1:0]         o_m_axis_tdata,
    output logic [depq_pkg::STATUS_W-1:0]      o_m_axis_tuser   // status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [depq_pkg::DATA_W-1:0] w_lo    [CAPACITY];
    logic signed [depq_pkg::DATA_W-1:0] w_hi    [CAPACITY];
    logic                               w_lo_le [CAPACITY];
    logic                               w_hi_ge [CAPACITY];

    logic [CNT_W-1:0]                   r_count;
    logic [CNT_W-1:0]                   n_count;
    logic                               r_pend;
    logic [depq_pkg::STATUS_W-1:0]      r_status;
    logic [depq_pkg::STATUS_W-1:0]      n_status;
    logic                               r_ovalid;
    logic [depq_pkg::RES_W-1:0]         r_odata;
    logic [depq_pkg::STATUS_W-1:0]      r_ouser;

    logic                               w_accept;
    logic                               w_load;
    logic                               w_full;
    logic                               w_empty;
    logic signed [depq_pkg::DATA_W-1:0] w_value;
    depq_pkg::t_cell_op                 w_op;
    logic signed [depq_pkg::DATA_W-1:0] w_min;
    logic signed [depq_pkg::DATA_W-1:0] w_max;

    assign w_accept = i_s_axis_tvalid && !r_pend;
    assign w_load   = r_pend && (!r_ovalid || i_m_axis_tready);
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_value  = $signed(i_s_axis_tdata);

    // Operation decode against the current fill level.
    always_comb begin
        w_op     = '0;
        n_status = depq_pkg::ST_DONE;
        n_count  = r_count;
        unique case (i_s_axis_tuser)
            depq_pkg::FN_INSERT: begin
                if (w_full) begin
                    n_status = depq_pkg::ST_FULL;
                end else begin
                    w_op.ins = w_accept;
                    n_count  = r_count + 1'b1;
                end
            end
            depq_pkg::FN_POP_MAX: begin
                if (w_empty) begin
                    n_status = depq_pkg::ST_EMPTY;
                end else begin
                    w_op.pop_max = w_accept;
                    n_count      = r_count - 1'b1;
                end
            end
            depq_pkg::FN_POP_MIN: begin
                if (w_empty) begin
                    n_status = depq_pkg::ST_EMPTY;
                end else begin
                    w_op.pop_min = w_accept;
                    n_count      = r_count - 1'b1;
                end
            end
            default: begin
                n_status = depq_pkg::ST_DONE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [depq_pkg::DATA_W-1:0] w_left_lo;
            logic signed [depq_pkg::DATA_W-1:0] w_left_hi;
            logic                               w_left_le;
            logic                               w_left_ge;
            logic signed [depq_pkg::DATA_W-1:0] w_right_lo;
            logic signed [depq_pkg::DATA_W-1:0] w_right_hi;

            if (gi == 0) begin : g_first
                // The head cell is always the insertion point if nothing holds.
                assign w_left_lo = w_value;
                assign w_left_hi = w_value;
                assign w_left_le = 1'b1;
                assign w_left_ge = 1'b1;
            end else begin : g_inner
                assign w_left_lo = w_lo[gi-1];
                assign w_left_hi = w_hi[gi-1];
                assign w_left_le = w_lo_le[gi-1];
                assign w_left_ge = w_hi_ge[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign w_right_lo = w_lo[gi];
                assign w_right_hi = w_hi[gi];
            end else begin : g_body
                assign w_right_lo = w_lo[gi+1];
                assign w_right_hi = w_hi[gi+1];
            end

            depq_cell u_cell (
                .i_clk      (i_clk),
                .i_op       (w_op),
                .i_value    (w_value),
                .i_live     (CNT_W'(gi) < r_count),
                .i_left_lo  (w_left_lo),
                .i_left_le  (w_left_le),
                .i_left_hi  (w_left_hi),
                .i_left_ge  (w_left_ge),
                .i_right_lo (w_right_lo),
                .i_right_hi (w_right_hi),
                .o_lo       (w_lo[gi]),
                .o_hi       (w_hi[gi]),
                .o_lo_le    (w_lo_le[gi]),
                .o_hi_ge    (w_hi_ge[gi])
            );
        end
    endgenerate

    assign w_min = w_empty ? depq_pkg::NO_VALUE : w_lo[0];
    assign w_max = w_empty ? depq_pkg::NO_VALUE : w_hi[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
            end else if (w_load) begin
                r_pend  <= 1'b0;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
        end
        if (w_load) begin
            r_ouser <= r_status;
            r_odata <= depq_pkg::RES_W'({depq_pkg::TOTAL_W'(r_count), w_max, w_min, w_empty});
        end
    end

    assign o_s_axis_tready = !r_pend;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

endmodule

>>> design/depq_checker.sv
// ----------------------------------------------------------------------------
// Double-ended priority queue checker
// Port-level properties of the queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_priority_queue_assert.svh"

module depq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               o_s_axis_tready,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [depq_pkg::RES_W-1:0]         o_m_axis_tdata,
    input  logic [depq_pkg::STATUS_W-1:0]      o_m_axis_tuser
);

    logic w_res_empty;
    logic w_out_stall;

    assign w_res_empty = o_m_axis_tdata[0];
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;

    `DEPQ_ASSERT_NXT(a_stall_hold, w_out_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    `DEPQ_ASSERT_IMP(a_empty_ends, o_m_axis_tvalid && w_res_empty, (o_m_axis_tdata[32:1] == depq_pkg::NO_VALUE) && (o_m_axis_tdata[64:33] == depq_pkg::NO_VALUE) && (o_m_axis_tdata[75:65] == '0), "empty result without all-ones ends")

    `DEPQ_ASSERT_IMP(a_min_le_max, o_m_axis_tvalid && !w_res_empty, $signed(o_m_axis_tdata[32:1]) <= $signed(o_m_axis_tdata[64:33]), "minimum above maximum")

    `DEPQ_ASSERT_IMP(a_empty_status, o_m_axis_tvalid && (o_m_axis_tuser == depq_pkg::ST_EMPTY), w_res_empty, "empty removal on a non-empty queue")

    `DEPQ_ASSERT_NXT(a_busy_after_req, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "request accepted while previous still pending")

endmodule

bind double_ended_priority_queue depq_checker u_depq_checker (.*);
